// ===== src/ura_pkg.sv =====
package ura_pkg;

	// Sizing of the echo timer and the averager.
	localparam int ECHO_COUNT_BITS = 20;
	localparam int MAX_SAMPLES = 8;

	// Register widths.
	localparam int CFG_TRIG_W = 8;
	localparam int CFG_SAMPLE_W = 4;
	localparam int CFG_TPC_W = 8;

	// Reset values of the registers.
	localparam logic [CFG_TRIG_W-1:0] TRIG_WIDTH_RST = 8'd20;
	localparam logic [CFG_SAMPLE_W-1:0] SAMPLE_COUNT_RST = 4'd5;
	localparam logic [CFG_TPC_W-1:0] TICKS_PER_CM_RST = 8'd58;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_TRIGGER_WIDTH = 2'd0;
	localparam logic [1:0] REG_SAMPLE_COUNT = 2'd1;
	localparam logic [1:0] REG_TICKS_PER_CM = 2'd2;

	// Derived widths.
	localparam int SAMPLE_W = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W = ECHO_COUNT_BITS + ((MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 0);
	localparam int FRAC_BITS = 4;
	localparam int DIVIDEND_W = SUM_W + FRAC_BITS;
	localparam int DIVISOR_W = CFG_TPC_W + SAMPLE_W;
	localparam int STEP_W = $clog2(DIVIDEND_W + 1);
	localparam int DIST_W = 16;

	// Status of the divider as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} ura_div_status_t;

endpackage

// ===== src/ura_div.sv =====
module ura_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [ura_pkg::DIVIDEND_W-1:0]  dividend,
	input  logic [ura_pkg::DIVISOR_W-1:0]   divisor,
	output ura_pkg::ura_div_status_t        status,
	output logic [ura_pkg::DIVIDEND_W-1:0]  quotient
);
	import ura_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     step_q;
	logic [DIVIDEND_W-1:0] work_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  divisor_q;

	logic [DIVISOR_W:0]    rem_shift;
	logic [DIVISOR_W:0]    trial;
	logic                  fits;

	// One restoring step: bring down the next dividend bit and try the subtraction.
	always_comb begin
		rem_shift = {rem_q, work_q[DIVIDEND_W-1]};
		trial = rem_shift - {1'b0, divisor_q};
		fits = (rem_shift >= {1'b0, divisor_q});
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIVIDEND_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend shifts out at the top while quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? trial[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient = work_q;

endmodule

// ===== src/ultrasonic_range_averager_core.sv =====
// Channel   Direction  Handshake            Contents
// s_*       in         s_tvalid / s_tready  one microsecond tick: start request, echo level
// m_*       out        m_tvalid / m_tready  one result per tick: trigger, busy, done, distance
// apb       in         psel & penable       trigger_width, sample_count, ticks_per_cm
//
// An ordinary tick passes straight to the output register; the tick that ends
// the last sample of a measurement waits for the bit-per-cycle restoring
// divider that forms the mean distance.
// s_tready falls while the divider runs and while a result waits on m_tready.
// Reset is asynchronous and clears the sequencer and the registers to their defaults.
module ultrasonic_range_averager_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] start_req, [1] echo_level, [7:2] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [0] trigger_level, [1] busy_res, [2] done_res,
	                               // [18:3] distance_sixteenths, [19] echo_overflow,
	                               // [23:20] zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ura_pkg::*;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_TRIG = 2'd1;
	localparam logic [1:0] PH_WAIT = 2'd2;
	localparam logic [1:0] PH_MEAS = 2'd3;

	// Configuration registers.
	logic [CFG_TRIG_W-1:0]   trig_width_q;
	logic [CFG_SAMPLE_W-1:0] sample_count_q;
	logic [CFG_TPC_W-1:0]    tpc_q;

	// Sequencer state.
	logic [1:0]                 phase_q;
	logic [CFG_TRIG_W-1:0]      trig_cnt_q;
	logic [ECHO_COUNT_BITS-1:0] echo_cnt_q;
	logic [SAMPLE_W-1:0]        taken_q;
	logic [SUM_W-1:0]           sum_q;
	logic                       ovf_seen_q;
	logic                       ovf_pend_q;

	// Output register.
	logic              out_valid_q;
	logic              out_trig_q;
	logic              out_busy_q;
	logic              out_done_q;
	logic [DIST_W-1:0] out_dist_q;
	logic              out_ovf_q;

	// Next-state values for an accepted item.
	logic [1:0]                 phase_d;
	logic [CFG_TRIG_W-1:0]      trig_cnt_d;
	logic [ECHO_COUNT_BITS-1:0] echo_cnt_d;
	logic [SAMPLE_W-1:0]        taken_d;
	logic [SUM_W-1:0]           sum_d;
	logic                       ovf_seen_d;
	logic                       trig_d;
	logic                       final_d;
	logic [CFG_TRIG_W-1:0]      trig_load;
	logic [CFG_TRIG_W-1:0]      trig_dec;
	logic [CFG_SAMPLE_W:0]      n_raw;
	logic [SAMPLE_W:0]          n_want;
	logic [SAMPLE_W:0]          taken_inc;
	logic [CFG_TPC_W-1:0]       tpc_eff;
	logic [DIVISOR_W-1:0]       divisor_d;

	logic                       in_accept;
	logic                       cfg_write;
	logic                       start_req;
	logic                       echo_level;

	ura_div_status_t            div_status;
	logic [DIVIDEND_W-1:0]      quotient;
	logic [DIST_W-1:0]          dist_sat;

	assign start_req = s_tdata[0];
	assign echo_level = s_tdata[1];

	assign s_tready = !div_status.busy && !div_status.done && (!out_valid_q || m_tready);
	assign in_accept = s_tvalid && s_tready;
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_width_q <= TRIG_WIDTH_RST;
			sample_count_q <= SAMPLE_COUNT_RST;
			tpc_q <= TICKS_PER_CM_RST;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				REG_TRIGGER_WIDTH: trig_width_q <= pwdata[CFG_TRIG_W-1:0];
				REG_SAMPLE_COUNT:  sample_count_q <= pwdata[CFG_SAMPLE_W-1:0];
				REG_TICKS_PER_CM:  tpc_q <= pwdata[CFG_TPC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register reads.
	always_comb begin
		unique case (paddr[3:2])
			REG_TRIGGER_WIDTH: prdata = 32'(trig_width_q);
			REG_SAMPLE_COUNT:  prdata = 32'(sample_count_q);
			REG_TICKS_PER_CM:  prdata = 32'(tpc_q);
			default:           prdata = '0;
		endcase
	end

	// Register values as used: zero widths and counts are taken as one,
	// and the sample count is capped.
	always_comb begin
		trig_load = (trig_width_q == '0) ? CFG_TRIG_W'(1) : trig_width_q;
		tpc_eff = (tpc_q == '0) ? CFG_TPC_W'(1) : tpc_q;
		n_raw = {1'b0, sample_count_q};
		if (n_raw == '0) begin
			n_raw = (CFG_SAMPLE_W+1)'(1);
		end else if (n_raw > (CFG_SAMPLE_W+1)'(MAX_SAMPLES)) begin
			n_raw = (CFG_SAMPLE_W+1)'(MAX_SAMPLES);
		end
		n_want = (SAMPLE_W+1)'(n_raw);
	end

	// One tick of the trigger, echo and averaging sequence.
	always_comb begin
		phase_d = phase_q;
		trig_cnt_d = trig_cnt_q;
		echo_cnt_d = echo_cnt_q;
		taken_d = taken_q;
		sum_d = sum_q;
		ovf_seen_d = ovf_seen_q;
		trig_d = 1'b0;
		final_d = 1'b0;
		trig_dec = (trig_cnt_q != '0) ? trig_cnt_q - 1'b1 : trig_cnt_q;
		taken_inc = {1'b0, taken_q} + 1'b1;
		unique case (phase_q)
			PH_IDLE: begin
				if (start_req) begin
					taken_d = '0;
					sum_d = '0;
					ovf_seen_d = 1'b0;
					echo_cnt_d = '0;
					trig_cnt_d = trig_load;
					phase_d = PH_TRIG;
				end
			end
			PH_TRIG: begin
				trig_d = 1'b1;
				trig_cnt_d = trig_dec;
				if (trig_dec == '0) begin
					phase_d = PH_WAIT;
				end
			end
			PH_WAIT: begin
				if (echo_level) begin
					echo_cnt_d = ECHO_COUNT_BITS'(1);
					phase_d = PH_MEAS;
				end
			end
			default: begin
				if (echo_level) begin
					if (echo_cnt_q == '1) begin
						ovf_seen_d = 1'b1;
					end else begin
						echo_cnt_d = echo_cnt_q + 1'b1;
					end
				end else begin
					sum_d = sum_q + SUM_W'(echo_cnt_q);
					echo_cnt_d = '0;
					taken_d = taken_inc[SAMPLE_W-1:0];
					if (taken_inc >= n_want) begin
						final_d = 1'b1;
						taken_d = '0;
						phase_d = PH_IDLE;
					end else begin
						trig_cnt_d = trig_load;
						phase_d = PH_TRIG;
					end
				end
			end
		endcase
		divisor_d = DIVISOR_W'(tpc_eff) * DIVISOR_W'(taken_inc[SAMPLE_W-1:0]);
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			trig_cnt_q <= '0;
			echo_cnt_q <= '0;
			taken_q <= '0;
			sum_q <= '0;
			ovf_seen_q <= 1'b0;
		end else if (in_accept) begin
			phase_q <= phase_d;
			trig_cnt_q <= trig_cnt_d;
			echo_cnt_q <= echo_cnt_d;
			taken_q <= taken_d;
			sum_q <= sum_d;
			ovf_seen_q <= ovf_seen_d;
		end
	end

	// Overflow flag of the measurement that is being divided.
	always_ff @(posedge clk) begin
		if (in_accept && final_d) begin
			ovf_pend_q <= ovf_seen_d;
		end
	end

	// The divider forms the mean distance from the echo sum.
	ura_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_accept && final_d),
		.dividend ({sum_d, FRAC_BITS'(0)}),
		.divisor  (divisor_d),
		.status   (div_status),
		.quotient (quotient)
	);

	assign dist_sat = (|quotient[DIVIDEND_W-1:DIST_W]) ? '1 : quotient[DIST_W-1:0];

	// Output register: an ordinary tick loads it at once, the closing tick
	// loads it when the divider finishes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (div_status.done || (in_accept && !final_d)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_status.done) begin
			out_trig_q <= 1'b0;
			out_busy_q <= 1'b0;
			out_done_q <= 1'b1;
			out_dist_q <= dist_sat;
			out_ovf_q <= ovf_pend_q;
		end else if (in_accept && !final_d) begin
			out_trig_q <= trig_d;
			out_busy_q <= (phase_d != PH_IDLE);
			out_done_q <= 1'b0;
			out_dist_q <= '0;
			out_ovf_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {4'b0000, out_ovf_q, out_dist_q, out_done_q, out_busy_q, out_trig_q};

endmodule
